### hdl/sbc_pkg.sv
`default_nettype none
package sbc_pkg;

	// Coordinate width; the widths below follow from it, apart from NRM_W, FRAC_W and DIV_Q_W.
	localparam int CW        = 32;
	localparam int RAD_W     = CW - 1;
	localparam int SV_W      = CW + 2;
	localparam int DIST_W    = 2 * RAD_W + 2;
	localparam int SQ_IN_W   = 2 * SV_W;
	localparam int SQ_OUT_W  = SV_W;
	localparam int NRM_W     = 18;
	localparam int FRAC_W    = 16;
	localparam int DIV_Q_W   = FRAC_W + 1;
	localparam int DIV_NUM_W = SV_W + FRAC_W + 1;
	localparam int FRONT_STAGES = 4;
	localparam int PIPE_STAGES  = FRONT_STAGES + SQ_OUT_W + DIV_Q_W;
	localparam int IN_BITS   = 8 * ((9 * CW + 2 * RAD_W + 7) / 8);
	localparam int OUT_BITS  = 8 * ((3 * NRM_W + 2 * RAD_W + 7) / 8);

	typedef struct packed {
		logic                       hit;
		logic [RAD_W-1:0]           r;
		logic [RAD_W-1:0]           bounce;
		logic [2:0]                 vneg;
		logic [2:0][SV_W-1:0]       av;
	} side_t;

endpackage
`default_nettype wire

### hdl/sphere_box_contact_top.sv
// Pipeline: an accepted item passes 4 front, 34 square-root, 17 divider and 1 output register
// stages in that order; the square root and divider retire one bit per stage.
// Throughput: one item per cycle while the skid register is empty.
// A stalled output lets the pipeline run until an item reaches its end; a skid register holds it.
// Reset (arst_n low, asynchronous) clears all valid bits and the output handshake;
// data registers are not reset.
`default_nettype none
module sphere_box_contact_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0 up: sphere_x, sphere_y, sphere_z, sphere_radius,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, bounce_in.
	input  wire logic [sbc_pkg::IN_BITS-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// Fields from bit 0 up: normal_x, normal_y, normal_z, depth, bounce_out.
	output logic [sbc_pkg::OUT_BITS-1:0]       m_tdata,
	// Field: hit.
	output logic [0:0]                         m_tuser
);
	localparam int CW   = sbc_pkg::CW;
	localparam int RW   = sbc_pkg::RAD_W;
	localparam int NW   = sbc_pkg::NRM_W;
	localparam int SQN  = sbc_pkg::SQ_OUT_W;
	localparam int DQN  = sbc_pkg::DIV_Q_W;
	localparam int PN   = sbc_pkg::PIPE_STAGES;
	localparam int SIDE_N = SQN + DQN;
	localparam int RAD_LSB = 3 * CW;
	localparam int MIN_LSB = RAD_LSB + RW;
	localparam int MAX_LSB = MIN_LSB + 3 * CW;
	localparam int BNC_LSB = MAX_LSB + 3 * CW;
	localparam int RES_BITS = 3 * NW + 2 * RW;

	// The whole pipeline moves together; it stops only while the skid register holds an item.
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign s_tready = en;

	// Unpack the input item.
	logic [2:0][CW-1:0] sph, bmin, bmax;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sph[i]  = s_tdata[i*CW +: CW];
			bmin[i] = s_tdata[MIN_LSB + i*CW +: CW];
			bmax[i] = s_tdata[MAX_LSB + i*CW +: CW];
		end
	end

	// Valid bits that travel beside the data, one per pipeline stage.
	logic [PN-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PN-2:0], s_tvalid};
		end
	end

	// Front: clamp, hit test, normal vector and its squared length.
	logic [sbc_pkg::SQ_IN_W-1:0] dist_sq, sumsq;
	sbc_pkg::side_t              side_f;
	sbc_front u_front (
		.clk(clk), .en(en), .sph(sph), .bmin(bmin), .bmax(bmax),
		.radius(s_tdata[RAD_LSB +: RW]), .bounce(s_tdata[BNC_LSB +: RW]),
		.dist_sq(dist_sq), .sumsq(sumsq), .side(side_f)
	);

	// Two square roots side by side: distance to the box and normal length.
	logic [SQN-1:0] sqd, len;
	sbc_sqrt u_sqrt_dist (.clk(clk), .en(en), .x(dist_sq), .root(sqd));
	sbc_sqrt u_sqrt_len  (.clk(clk), .en(en), .x(sumsq),   .root(len));

	// Item data that waits beside the square roots and dividers.
	sbc_pkg::side_t side_s [SIDE_N];
	logic [SQN-1:0] sqd_s  [DQN];
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_f;
			for (int k = 1; k < SIDE_N; k++) begin
				side_s[k] <= side_s[k-1];
			end
			sqd_s[0] <= sqd;
			for (int k = 1; k < DQN; k++) begin
				sqd_s[k] <= sqd_s[k-1];
			end
		end
	end

	// One divider lane per axis scales each part to unit length.
	logic [2:0][DQN-1:0] qv;
	for (genvar i = 0; i < 3; i++) begin : g_lane
		sbc_div u_div (
			.clk(clk), .en(en), .a(side_s[SQN-1].av[i]), .len(len), .q(qv[i])
		);
	end

	// Final result: signs, depth, and zeros for a miss.
	sbc_pkg::side_t          sl;
	logic [2:0][NW-1:0]      nrm;
	logic [RW-1:0]           dep, bnc;
	logic [RES_BITS-1:0]     res;
	always_comb begin
		sl = side_s[SIDE_N-1];
		for (int i = 0; i < 3; i++) begin
			if (sl.hit && sl.av[i] != '0) begin
				nrm[i] = sl.vneg[i] ? NW'(-NW'(qv[i])) : NW'(qv[i]);
			end else begin
				nrm[i] = '0;
			end
		end
		dep = sl.hit ? (sl.r - sqd_s[DQN-1][RW-1:0]) : '0;
		bnc = sl.hit ? sl.bounce : '0;
		res = {bnc, dep, nrm[2], nrm[1], nrm[0]};
	end

	// Output register with a skid register behind it.
	logic [RES_BITS-1:0] out_q, skid_q;
	logic                hit_q, skid_hit_q, out_v_q, take;
	assign take = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_s[PN-1]) begin
			out_v_q <= 1'b1;
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
				hit_q <= skid_hit_q;
			end
		end else if (vld_s[PN-1]) begin
			if (!out_v_q || take) begin
				out_q <= res;
				hit_q <= sl.hit;
			end else begin
				skid_q     <= res;
				skid_hit_q <= sl.hit;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = sbc_pkg::OUT_BITS'(out_q);
	assign m_tuser  = hit_q;

	// The skid register is only ever filled behind a waiting output item.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid holds an item with empty output");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid filled without a stall");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss carries nonzero fields");

	a_no_input_on_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("item entered while stalled");

endmodule
`default_nettype wire

### hdl/sbc_front.sv
`default_nettype none
module sbc_front (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [2:0][sbc_pkg::CW-1:0]       sph,
	input  wire logic [2:0][sbc_pkg::CW-1:0]       bmin,
	input  wire logic [2:0][sbc_pkg::CW-1:0]       bmax,
	input  wire logic [sbc_pkg::RAD_W-1:0]         radius,
	input  wire logic [sbc_pkg::RAD_W-1:0]         bounce,
	output logic [sbc_pkg::SQ_IN_W-1:0]            dist_sq,
	output logic [sbc_pkg::SQ_IN_W-1:0]            sumsq,
	output sbc_pkg::side_t                         side
);
	localparam int SV = sbc_pkg::SV_W;
	localparam int RW = sbc_pkg::RAD_W;

	logic signed [SV-1:0] se [3];
	logic signed [SV-1:0] lo [3];
	logic signed [SV-1:0] hi [3];
	logic signed [SV-1:0] cl [3];
	logic signed [SV-1:0] dd [3];
	logic signed [SV-1:0] vv [3];
	logic [SV-1:0]        dmag [3];
	logic [2:0]           near;

	// Stage 1: clamp into the box, axis distance and radius test, doubled offset from the box center.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			se[i] = SV'($signed(sph[i]));
			lo[i] = SV'($signed(bmin[i]));
			hi[i] = SV'($signed(bmax[i]));
			cl[i] = (se[i] < hi[i]) ? se[i] : hi[i];
			if (lo[i] > cl[i]) begin
				cl[i] = lo[i];
			end
			dd[i]   = se[i] - cl[i];
			dmag[i] = dd[i][SV-1] ? SV'(-dd[i]) : SV'(dd[i]);
			near[i] = dmag[i] < SV'(radius);
			vv[i]   = (se[i] <<< 1) - lo[i] - hi[i];
		end
	end

	logic [2:0][RW-1:0] ad_s1;
	logic [2:0][SV-1:0] av_s1;
	logic [2:0]         vneg_s1;
	logic               near_s1;
	logic [RW-1:0]      r_s1, b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ad_s1[i]   <= dmag[i][RW-1:0];
				av_s1[i]   <= vv[i][SV-1] ? SV'(-vv[i]) : SV'(vv[i]);
				vneg_s1[i] <= vv[i][SV-1];
			end
			near_s1 <= &near;
			r_s1    <= radius;
			b_s1    <= bounce;
		end
	end

	// Stage 2: keep only a strictly dominant axis; square the axis distances and the radius.
	logic [2:0][SV-1:0] avm;
	always_comb begin
		avm = av_s1;
		if (av_s1[0] > av_s1[1] && av_s1[0] > av_s1[2]) begin
			avm[1] = '0;
			avm[2] = '0;
		end else if (av_s1[1] > av_s1[0] && av_s1[1] > av_s1[2]) begin
			avm[0] = '0;
			avm[2] = '0;
		end else if (av_s1[2] > av_s1[0] && av_s1[2] > av_s1[1]) begin
			avm[0] = '0;
			avm[1] = '0;
		end
	end

	logic [2:0][2*RW-1:0] adsq_s2;
	logic [2*RW-1:0]      rr_s2;
	logic [2:0][SV-1:0]   av_s2;
	logic [2:0]           vneg_s2;
	logic                 near_s2;
	logic [RW-1:0]        r_s2, b_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				adsq_s2[i] <= (2*RW)'(ad_s1[i]) * (2*RW)'(ad_s1[i]);
			end
			rr_s2   <= (2*RW)'(r_s1) * (2*RW)'(r_s1);
			av_s2   <= avm;
			vneg_s2 <= vneg_s1;
			near_s2 <= near_s1;
			r_s2    <= r_s1;
			b_s2    <= b_s1;
		end
	end

	// Stage 3: squared distance against squared radius; square the normal parts.
	logic [sbc_pkg::DIST_W-1:0] dsum;
	assign dsum = sbc_pkg::DIST_W'(adsq_s2[0]) + sbc_pkg::DIST_W'(adsq_s2[1])
		+ sbc_pkg::DIST_W'(adsq_s2[2]);

	logic [2:0][sbc_pkg::SQ_IN_W-1:0] avsq_s3;
	logic [sbc_pkg::DIST_W-1:0]       dist_s3;
	sbc_pkg::side_t                   side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				avsq_s3[i] <= sbc_pkg::SQ_IN_W'(av_s2[i]) * sbc_pkg::SQ_IN_W'(av_s2[i]);
			end
			dist_s3        <= dsum;
			side_s3.hit    <= near_s2 && (dsum < sbc_pkg::DIST_W'(rr_s2));
			side_s3.r      <= r_s2;
			side_s3.bounce <= b_s2;
			side_s3.vneg   <= vneg_s2;
			side_s3.av     <= av_s2;
		end
	end

	// Stage 4: sum of squares of the normal vector.
	always_ff @(posedge clk) begin
		if (en) begin
			sumsq   <= avsq_s3[0] + avsq_s3[1] + avsq_s3[2];
			dist_sq <= sbc_pkg::SQ_IN_W'(dist_s3);
			side    <= side_s3;
		end
	end

endmodule
`default_nettype wire

### hdl/sbc_sqrt.sv
`default_nettype none
module sbc_sqrt (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [sbc_pkg::SQ_IN_W-1:0]  x,
	output logic [sbc_pkg::SQ_OUT_W-1:0]      root
);
	localparam int XW = sbc_pkg::SQ_IN_W;
	localparam int RW = sbc_pkg::SQ_OUT_W;

	// One result bit per stage, most significant first.
	logic [XW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		localparam int B = RW - 1 - k;
		logic [XW-1:0] rem_i, trial;
		logic [RW-1:0] root_i;
		if (k == 0) begin : g_first
			assign rem_i  = x;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end
		assign trial = (XW'(root_i) << (B + 1)) | (XW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[k]  <= rem_i - trial;
					root_s[k] <= root_i | (RW'(1) << B);
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i;
				end
			end
		end
	end

	assign root = root_s[RW-1];

endmodule
`default_nettype wire

### hdl/sbc_div.sv
`default_nettype none
module sbc_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [sbc_pkg::SV_W-1:0]      a,
	input  wire logic [sbc_pkg::SQ_OUT_W-1:0]  len,
	output logic [sbc_pkg::DIV_Q_W-1:0]        q
);
	localparam int NW = sbc_pkg::DIV_NUM_W;
	localparam int QW = sbc_pkg::DIV_Q_W;
	localparam int LW = sbc_pkg::SQ_OUT_W;

	// Restoring division of a * 2^16 by len, one quotient bit per stage.
	logic [NW-1:0] num_s [QW];
	logic [LW-1:0] len_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int B = QW - 1 - k;
		logic [NW-1:0] num_i, t;
		logic [LW-1:0] len_i;
		logic [QW-1:0] q_i;
		if (k == 0) begin : g_first
			assign num_i = NW'(a) << sbc_pkg::FRAC_W;
			assign len_i = len;
			assign q_i   = '0;
		end else begin : g_next
			assign num_i = num_s[k-1];
			assign len_i = len_s[k-1];
			assign q_i   = q_s[k-1];
		end
		assign t = NW'(len_i) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k] <= len_i;
				if (t <= num_i) begin
					num_s[k] <= num_i - t;
					q_s[k]   <= q_i | (QW'(1) << B);
				end else begin
					num_s[k] <= num_i;
					q_s[k]   <= q_i;
				end
			end
		end
	end

	assign q = q_s[QW-1];

endmodule
`default_nettype wire
